[rtl/core/imufu_pkg.sv]
// shared types and constants for the imu fifo frame unpacker
package imufu_pkg;

  localparam int WORD_W    = 16;
  localparam int ROLL_W    = 48;
  localparam int TS_W      = 64;
  localparam int CFG_IDX_W = 3;
  localparam int POS_W     = 3;
  localparam int LEN_W     = 4;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACC_ENABLE      = 3'd0,
    REG_GYR_ENABLE      = 3'd1,
    REG_TEMP_ENABLE     = 3'd2,
    REG_TIME_ENABLE     = 3'd3,
    REG_ACC_DUMMY_WORD  = 3'd4,
    REG_GYR_DUMMY_WORD  = 3'd5,
    REG_TEMP_DUMMY_WORD = 3'd6
  } cfg_reg_t;

  // reset values of the configuration registers
  localparam logic              RST_ACC_ENABLE  = 1'b0;
  localparam logic              RST_GYR_ENABLE  = 1'b0;
  localparam logic              RST_TEMP_ENABLE = 1'b0;
  localparam logic              RST_TIME_ENABLE = 1'b1;
  localparam logic [WORD_W-1:0] RST_ACC_DUMMY   = 16'h7F01;
  localparam logic [WORD_W-1:0] RST_GYR_DUMMY   = 16'h7F02;
  localparam logic [WORD_W-1:0] RST_TEMP_DUMMY  = 16'h8000;

  // bit positions in the per-frame valid flags
  localparam int FLAG_ACC  = 0;
  localparam int FLAG_GYR  = 1;
  localparam int FLAG_TEMP = 2;

  // stream enables
  typedef struct packed {
    logic acc;
    logic gyr;
    logic temp;
    logic time_word;
  } enables_t;

  // where the current word falls in the frame
  typedef struct packed {
    logic             len_zero;
    logic [POS_W-1:0] pos_start;
    logic [POS_W-1:0] pos_next;
    logic             first;
    logic             last;
    logic             acc_hit;
    logic             gyr_hit;
    logic             temp_hit;
    logic             time_hit;
    logic [1:0]       idx;
  } slot_t;

endpackage

[rtl/core/imufu_if.sv]
// handshake channels of the imu fifo frame unpacker

// fifo word channel
interface imufu_word_if;
  logic        valid;
  logic        ready;
  logic [15:0] fifo_word;
  logic        batch_start;

  modport source (output valid, output fifo_word, output batch_start, input ready);
  modport sink (input valid, input fifo_word, input batch_start, output ready);
endinterface

// decoded frame channel
interface imufu_frame_if;
  logic               valid;
  logic               ready;
  logic               acc_valid;
  logic signed [15:0] acc_x;
  logic signed [15:0] acc_y;
  logic signed [15:0] acc_z;
  logic               gyr_valid;
  logic signed [15:0] gyr_x;
  logic signed [15:0] gyr_y;
  logic signed [15:0] gyr_z;
  logic               temp_valid;
  logic signed [15:0] temperature;
  logic [63:0]        timestamp;

  modport source (output valid, output acc_valid, output acc_x, output acc_y, output acc_z,
                  output gyr_valid, output gyr_x, output gyr_y, output gyr_z,
                  output temp_valid, output temperature, output timestamp, input ready);
  modport sink (input valid, input acc_valid, input acc_x, input acc_y, input acc_z,
                input gyr_valid, input gyr_x, input gyr_y, input gyr_z,
                input temp_valid, input temperature, input timestamp, output ready);
endinterface

// configuration write channel
interface imufu_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/core/imufu_slot_decode.sv]
// frame position decoder: frame length, slot of the current word, next position
module imufu_slot_decode
  import imufu_pkg::*;
(
  input  enables_t         en,
  input  logic [POS_W-1:0] frame_position,
  input  logic             batch_start,
  output slot_t            slot
);

  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] gyr_off;
  logic [LEN_W-1:0] temp_off;
  logic [LEN_W-1:0] time_off;
  logic [LEN_W-1:0] gyr_rel;
  logic [POS_W-1:0] pos_start;
  logic [POS_W-1:0] pos;
  logic [LEN_W-1:0] pos4;

  // frame layout offsets
  always_comb begin
    gyr_off  = en.acc ? LEN_W'(3) : '0;
    temp_off = gyr_off + (en.gyr ? LEN_W'(3) : '0);
    time_off = temp_off + LEN_W'(en.temp);
    len      = time_off + LEN_W'(en.time_word);
  end

  // position of this word, realigned on batch start or a shrunk frame
  always_comb begin
    pos_start = batch_start ? '0 : frame_position;
    pos       = ({1'b0, pos_start} >= len) ? '0 : pos_start;
    pos4      = {1'b0, pos};
    gyr_rel   = pos4 - gyr_off;
  end

  // slot flags
  always_comb begin
    slot.len_zero  = (len == '0);
    slot.pos_start = pos_start;
    slot.first     = (pos == '0);
    slot.last      = ((pos4 + LEN_W'(1)) >= len);
    slot.pos_next  = slot.last ? '0 : pos + POS_W'(1);
    slot.acc_hit   = en.acc && (pos4 < LEN_W'(3));
    slot.gyr_hit   = en.gyr && (pos4 >= gyr_off) && (pos4 < gyr_off + LEN_W'(3));
    slot.temp_hit  = en.temp && (pos4 == temp_off);
    slot.time_hit  = en.time_word && (pos4 == time_off);
    slot.idx       = slot.acc_hit ? pos[1:0] : gyr_rel[1:0];
  end

endmodule

[rtl/core/imu_fifo_frame_unpacker.sv]
// top level of the imu fifo frame unpacker
//
// Parses 16-bit sensor FIFO words into frames (accel xyz, gyro xyz, temperature,
// time word, each only when enabled) and gives one result per frame at its last
// word. One word is taken every clock cycle: all per-word work (slot decode, dummy
// compare, 48-bit rollover increment) sits between the state registers and the
// result register. A result appears in the cycle after the word that ends its frame
// and stays in the result register until taken; a new word is taken in any cycle
// in which that register is empty or is being read out, so the rate drops below
// one word per cycle only while the result side stalls. Configuration writes are
// taken every cycle and are meant for idle periods.
module imu_fifo_frame_unpacker
  import imufu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  imufu_word_if.sink  words,
  imufu_frame_if.source result,
  imufu_cfg_if.sink   cfg
);

  // configuration registers
  enables_t          en;
  logic [WORD_W-1:0] acc_dummy_word;
  logic [WORD_W-1:0] gyr_dummy_word;
  logic [WORD_W-1:0] temp_dummy_word;

  // parser state
  logic [POS_W-1:0]  frame_position;
  logic [WORD_W-1:0] acc_capture [3];
  logic [WORD_W-1:0] gyr_capture [3];
  logic [WORD_W-1:0] acc_held [3];
  logic [WORD_W-1:0] gyr_held [3];
  logic [WORD_W-1:0] temp_held;
  logic [2:0]        frame_valid_flags;
  logic [WORD_W-1:0] previous_time_word;
  logic [ROLL_W-1:0] rollover_base;
  logic [TS_W-1:0]   held_timestamp;

  logic [WORD_W-1:0] acc_held_next [3];
  logic [WORD_W-1:0] gyr_held_next [3];
  logic [WORD_W-1:0] temp_held_next;
  logic [2:0]        flags_next;
  logic [ROLL_W-1:0] rollover_base_next;
  logic [TS_W-1:0]   held_timestamp_next;

  slot_t             slot;
  logic              accept;
  logic              emit;
  logic              acc_take;
  logic              gyr_take;
  logic [WORD_W-1:0] w;

  assign cfg.ready   = 1'b1;
  assign words.ready = !result.valid || result.ready;
  assign accept      = words.valid && words.ready;
  assign w           = words.fifo_word;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      en.acc          <= RST_ACC_ENABLE;
      en.gyr          <= RST_GYR_ENABLE;
      en.temp         <= RST_TEMP_ENABLE;
      en.time_word    <= RST_TIME_ENABLE;
      acc_dummy_word  <= RST_ACC_DUMMY;
      gyr_dummy_word  <= RST_GYR_DUMMY;
      temp_dummy_word <= RST_TEMP_DUMMY;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg_reg_t'(cfg.index))
        REG_ACC_ENABLE:      en.acc          <= cfg.data[0];
        REG_GYR_ENABLE:      en.gyr          <= cfg.data[0];
        REG_TEMP_ENABLE:     en.temp         <= cfg.data[0];
        REG_TIME_ENABLE:     en.time_word    <= cfg.data[0];
        REG_ACC_DUMMY_WORD:  acc_dummy_word  <= cfg.data;
        REG_GYR_DUMMY_WORD:  gyr_dummy_word  <= cfg.data;
        REG_TEMP_DUMMY_WORD: temp_dummy_word <= cfg.data;
        default: ;
      endcase
    end
  end

  imufu_slot_decode u_slot_decode (
    .en             (en),
    .frame_position (frame_position),
    .batch_start    (words.batch_start),
    .slot           (slot)
  );

  // triple completes on its third word, kept unless the first word is the dummy
  assign acc_take = slot.acc_hit && (slot.idx == 2'd2) && (acc_capture[0] != acc_dummy_word);
  assign gyr_take = slot.gyr_hit && (slot.idx == 2'd2) && (gyr_capture[0] != gyr_dummy_word);

  // next held samples, flags and time
  always_comb begin
    acc_held_next[0] = acc_take ? acc_capture[0] : acc_held[0];
    acc_held_next[1] = acc_take ? acc_capture[1] : acc_held[1];
    acc_held_next[2] = acc_take ? w : acc_held[2];
    gyr_held_next[0] = gyr_take ? gyr_capture[0] : gyr_held[0];
    gyr_held_next[1] = gyr_take ? gyr_capture[1] : gyr_held[1];
    gyr_held_next[2] = gyr_take ? w : gyr_held[2];

    flags_next = slot.first ? 3'b000 : frame_valid_flags;
    if (acc_take) begin
      flags_next[FLAG_ACC] = 1'b1;
    end
    if (gyr_take) begin
      flags_next[FLAG_GYR] = 1'b1;
    end

    temp_held_next = temp_held;
    if (slot.temp_hit && (w != temp_dummy_word)) begin
      temp_held_next        = w;
      flags_next[FLAG_TEMP] = 1'b1;
    end

    rollover_base_next  = rollover_base;
    held_timestamp_next = held_timestamp;
    if (slot.time_hit) begin
      if (previous_time_word > w) begin
        rollover_base_next = rollover_base + ROLL_W'(1);
      end
      held_timestamp_next = {rollover_base_next, w};
    end
  end

  assign emit = accept && !slot.len_zero && slot.last;

  // parser state update
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position     <= '0;
      frame_valid_flags  <= '0;
      temp_held          <= '0;
      previous_time_word <= '0;
      rollover_base      <= '0;
      held_timestamp     <= '0;
      for (int i = 0; i < 3; i++) begin
        acc_capture[i] <= '0;
        gyr_capture[i] <= '0;
        acc_held[i]    <= '0;
        gyr_held[i]    <= '0;
      end
    end else if (accept) begin
      if (slot.len_zero) begin
        frame_position <= slot.pos_start;
      end else begin
        frame_position    <= slot.pos_next;
        frame_valid_flags <= slot.last ? 3'b000 : flags_next;
        if (slot.acc_hit) begin
          acc_capture[slot.idx] <= w;
        end
        if (slot.gyr_hit) begin
          gyr_capture[slot.idx] <= w;
        end
        for (int i = 0; i < 3; i++) begin
          acc_held[i] <= acc_held_next[i];
          gyr_held[i] <= gyr_held_next[i];
        end
        temp_held      <= temp_held_next;
        rollover_base  <= rollover_base_next;
        held_timestamp <= held_timestamp_next;
        if (slot.time_hit) begin
          previous_time_word <= w;
        end
      end
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (emit) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (emit) begin
      result.acc_valid   <= flags_next[FLAG_ACC];
      result.acc_x       <= $signed(acc_held_next[0]);
      result.acc_y       <= $signed(acc_held_next[1]);
      result.acc_z       <= $signed(acc_held_next[2]);
      result.gyr_valid   <= flags_next[FLAG_GYR];
      result.gyr_x       <= $signed(gyr_held_next[0]);
      result.gyr_y       <= $signed(gyr_held_next[1]);
      result.gyr_z       <= $signed(gyr_held_next[2]);
      result.temp_valid  <= flags_next[FLAG_TEMP];
      result.temperature <= $signed(temp_held_next);
      result.timestamp   <= held_timestamp_next;
    end
  end

  // a word that ends a frame always loads the result register
  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    accept && !slot.len_zero && slot.last |=> result.valid)
    else $error("frame end did not produce a result");

  // each word of a live frame lands in exactly one slot
  a_one_slot: assert property (@(posedge clk) disable iff (rst)
    accept && !slot.len_zero |->
      $onehot({slot.acc_hit, slot.gyr_hit, slot.temp_hit, slot.time_hit}))
    else $error("word decoded to no slot or several slots");

  // the rollover base advances by at most one per cycle
  a_roll_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (rollover_base == $past(rollover_base)) ||
             (rollover_base == $past(rollover_base) + ROLL_W'(1)))
    else $error("rollover base jumped");

  // words taken while every stream is off never make a result
  a_idle_no_result: assert property (@(posedge clk) disable iff (rst)
    accept && slot.len_zero && !result.valid |=> !result.valid)
    else $error("result produced with no stream enabled");

endmodule

[sim/tb_imu_fifo_frame_unpacker.sv]
// testbench for the imu fifo frame unpacker: directed table, random frames, frame checker
`timescale 1ns / 1ps

module tb_imu_fifo_frame_unpacker;
  import imufu_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int SETTING_WORDS = 63;
  localparam int SRC_IDLE[4]   = '{0, 52, 0, 21};
  localparam int SINK_STALL[4] = '{0, 0, 52, 21};

  typedef struct packed {
    logic        acc_valid;
    logic [15:0] acc_x;
    logic [15:0] acc_y;
    logic [15:0] acc_z;
    logic        gyr_valid;
    logic [15:0] gyr_x;
    logic [15:0] gyr_y;
    logic [15:0] gyr_z;
    logic        temp_valid;
    logic [15:0] temperature;
    logic [63:0] timestamp;
  } frame_t;

  typedef enum {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [15:0] word;
    logic        bs;
    bit          typed;
    frame_t      frame;
    enables_t    en;
    logic [15:0] acc_dummy;
    logic [15:0] gyr_dummy;
    logic [15:0] temp_dummy;
  } row_t;

  logic clk;
  logic rst;

  imufu_word_if  word_ch ();
  imufu_frame_if frame_ch ();
  imufu_cfg_if   cfg_ch ();

  imu_fifo_frame_unpacker dut (
    .clk    (clk),
    .rst    (rst),
    .words  (word_ch),
    .result (frame_ch),
    .cfg    (cfg_ch)
  );

  // shadow of the block: registers and parser state
  enables_t    en;
  logic [15:0] acc_dummy, gyr_dummy, temp_dummy;
  int          frame_pos;
  logic [15:0] acc_cap[3], gyr_cap[3], acc_hold[3], gyr_hold[3];
  logic [15:0] temp_hold;
  logic [2:0]  frame_flags;
  logic [15:0] last_time_word;
  logic [47:0] roll_count;
  logic [63:0] ts_hold;

  frame_t      pending_frames[$];
  frame_t      table_frame;
  bit          table_frame_on;
  int          src_idle_pct;
  int          sink_stall_pct;
  int          mismatches;
  int          frames_checked;
  int          words_sent;
  int          settings_used;
  int          quiet_cycles;
  logic [15:0] time_clock;
  bit          restart_next;
  row_t        dir_rows[$];

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void model_reset();
    en         = '{acc: RST_ACC_ENABLE, gyr: RST_GYR_ENABLE, temp: RST_TEMP_ENABLE,
                   time_word: RST_TIME_ENABLE};
    acc_dummy  = RST_ACC_DUMMY;
    gyr_dummy  = RST_GYR_DUMMY;
    temp_dummy = RST_TEMP_DUMMY;
    frame_pos  = 0;
    for (int i = 0; i < 3; i++) begin
      acc_cap[i]  = '0;
      gyr_cap[i]  = '0;
      acc_hold[i] = '0;
      gyr_hold[i] = '0;
    end
    temp_hold      = '0;
    frame_flags    = '0;
    last_time_word = '0;
    roll_count     = '0;
    ts_hold        = '0;
  endfunction

  function automatic int frame_len();
    return (en.acc ? 3 : 0) + (en.gyr ? 3 : 0) + (en.temp ? 1 : 0) + (en.time_word ? 1 : 0);
  endfunction

  function automatic void apply_reg(cfg_reg_t idx, logic [15:0] d);
    case (idx)
      REG_ACC_ENABLE:      en.acc       = d[0];
      REG_GYR_ENABLE:      en.gyr       = d[0];
      REG_TEMP_ENABLE:     en.temp      = d[0];
      REG_TIME_ENABLE:     en.time_word = d[0];
      REG_ACC_DUMMY_WORD:  acc_dummy    = d;
      REG_GYR_DUMMY_WORD:  gyr_dummy    = d;
      REG_TEMP_DUMMY_WORD: temp_dummy   = d;
      default: ;
    endcase
  endfunction

  // a triple counts only if its first word is not the dummy pattern
  function automatic void capture_triple(inout logic [15:0] cap[3], inout logic [15:0] hold[3],
                                         input int idx, input logic [15:0] w,
                                         input logic [15:0] dummy, input int flag);
    cap[idx] = w;
    if (idx == 2 && cap[0] != dummy) begin
      hold = cap;
      frame_flags[flag] = 1'b1;
    end
  endfunction

  // advance the parser by one word; returns 1 when the word closes a frame
  function automatic bit predict_frame(input logic [15:0] w, input logic bs, output frame_t f);
    int len;
    int gyr_base;
    int temp_base;
    int time_base;
    f = '0;
    len       = frame_len();
    gyr_base  = en.acc ? 3 : 0;
    temp_base = gyr_base + (en.gyr ? 3 : 0);
    time_base = temp_base + (en.temp ? 1 : 0);
    if (bs) frame_pos = 0;
    if (len == 0) return 1'b0;
    if (frame_pos >= len) frame_pos = 0;
    if (frame_pos == 0) frame_flags = '0;

    if (en.acc && frame_pos < 3) begin
      capture_triple(acc_cap, acc_hold, frame_pos, w, acc_dummy, FLAG_ACC);
    end else if (en.gyr && frame_pos >= gyr_base && frame_pos < gyr_base + 3) begin
      capture_triple(gyr_cap, gyr_hold, frame_pos - gyr_base, w, gyr_dummy, FLAG_GYR);
    end else if (en.temp && frame_pos == temp_base) begin
      if (w != temp_dummy) begin
        temp_hold = w;
        frame_flags[FLAG_TEMP] = 1'b1;
      end
    end else if (en.time_word && frame_pos == time_base) begin
      // time word going backwards means the sensor counter wrapped
      if (last_time_word > w) roll_count = roll_count + 1'b1;
      last_time_word = w;
      ts_hold = {roll_count, w};
    end

    if (frame_pos + 1 < len) begin
      frame_pos++;
      return 1'b0;
    end
    frame_pos     = 0;
    f.acc_valid   = frame_flags[FLAG_ACC];
    f.acc_x       = acc_hold[0];
    f.acc_y       = acc_hold[1];
    f.acc_z       = acc_hold[2];
    f.gyr_valid   = frame_flags[FLAG_GYR];
    f.gyr_x       = gyr_hold[0];
    f.gyr_y       = gyr_hold[1];
    f.gyr_z       = gyr_hold[2];
    f.temp_valid  = frame_flags[FLAG_TEMP];
    f.temperature = temp_hold;
    f.timestamp   = ts_hold;
    frame_flags   = '0;
    return 1'b1;
  endfunction

  task automatic check_field(input string fname, input logic [63:0] want,
                             input logic [63:0] seen);
    if (want !== seen) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, fname, want, seen);
    end
  endtask

  // monitor: register writes, word transfers and frame checks
  always @(posedge clk) begin : monitor
    frame_t seen;
    frame_t want;
    frame_t calc;
    bit     made;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) apply_reg(cfg_reg_t'(cfg_ch.index), cfg_ch.data);

      if (frame_ch.valid && frame_ch.ready) begin
        seen = {frame_ch.acc_valid, frame_ch.acc_x, frame_ch.acc_y, frame_ch.acc_z,
                frame_ch.gyr_valid, frame_ch.gyr_x, frame_ch.gyr_y, frame_ch.gyr_z,
                frame_ch.temp_valid, frame_ch.temperature, frame_ch.timestamp};
        if (pending_frames.size() == 0) begin
          mismatches++;
          $display("%0t: frame with none expected: expected nothing, actual %h", $time, seen);
        end else begin
          want = pending_frames.pop_front();
          frames_checked++;
          check_field("acc_valid", want.acc_valid, seen.acc_valid);
          check_field("acc_x", want.acc_x, seen.acc_x);
          check_field("acc_y", want.acc_y, seen.acc_y);
          check_field("acc_z", want.acc_z, seen.acc_z);
          check_field("gyr_valid", want.gyr_valid, seen.gyr_valid);
          check_field("gyr_x", want.gyr_x, seen.gyr_x);
          check_field("gyr_y", want.gyr_y, seen.gyr_y);
          check_field("gyr_z", want.gyr_z, seen.gyr_z);
          check_field("temp_valid", want.temp_valid, seen.temp_valid);
          check_field("temperature", want.temperature, seen.temperature);
          check_field("timestamp", want.timestamp, seen.timestamp);
        end
      end

      if (word_ch.valid && word_ch.ready) begin
        made = predict_frame(word_ch.fifo_word, word_ch.batch_start, calc);
        if (made || table_frame_on) pending_frames.push_back(table_frame_on ? table_frame : calc);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (word_ch.valid && word_ch.ready) || (frame_ch.valid && frame_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d frames outstanding", $time,
               quiet_cycles, pending_frames.size());
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side stalls
  always @(negedge clk) begin
    frame_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic send_word(input logic [15:0] w, input logic bs, input bit typed,
                           input frame_t tf);
    while ($urandom_range(99) < src_idle_pct) begin
      word_ch.valid <= 1'b0;
      @(negedge clk);
    end
    if (frame_len() != 0) words_sent++;
    word_ch.valid       <= 1'b1;
    word_ch.fifo_word   <= w;
    word_ch.batch_start <= bs;
    table_frame_on      <= typed;
    table_frame         <= tf;
    do @(posedge clk); while (!word_ch.ready);
    @(negedge clk);
  endtask

  // stop sending until every expected frame has been taken
  task automatic wait_for_frames();
    word_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_frames.size() != 0);
  endtask

  task automatic drain();
    wait_for_frames();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
  endtask

  task automatic configure(input enables_t e, input logic [15:0] ad, input logic [15:0] gd,
                           input logic [15:0] td);
    write_reg(REG_ACC_ENABLE, {15'd0, e.acc});
    write_reg(REG_GYR_ENABLE, {15'd0, e.gyr});
    write_reg(REG_TEMP_ENABLE, {15'd0, e.temp});
    write_reg(REG_TIME_ENABLE, {15'd0, e.time_word});
    write_reg(REG_ACC_DUMMY_WORD, ad);
    write_reg(REG_GYR_DUMMY_WORD, gd);
    write_reg(REG_TEMP_DUMMY_WORD, td);
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  // one frame of the current layout, sometimes cut short or replaced by noise
  task automatic send_frame();
    logic [15:0] words[$];
    int          r;
    int          cut;
    logic        head_bs;
    if (en.acc) begin
      words.push_back(($urandom_range(3) == 0) ? acc_dummy : 16'($urandom));
      words.push_back(16'($urandom));
      words.push_back(16'($urandom));
    end
    if (en.gyr) begin
      words.push_back(($urandom_range(3) == 0) ? gyr_dummy : 16'($urandom));
      words.push_back(16'($urandom));
      words.push_back(16'($urandom));
    end
    if (en.temp) words.push_back(($urandom_range(3) == 0) ? temp_dummy : 16'($urandom));
    if (en.time_word) begin
      r = $urandom_range(9);
      if (r == 0) time_clock = 16'($urandom);
      else if (r == 1) time_clock = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      else time_clock = time_clock + 16'($urandom_range(1, 4000));
      words.push_back(time_clock);
    end

    r = $urandom_range(99);
    if (r < 8) begin
      // truncated frame, next one realigns with batch_start
      cut = $urandom_range(words.size() - 1);
      for (int i = 0; i < cut; i++) send_word(words[i], 1'b0, 1'b0, '0);
      restart_next = 1'b1;
    end else if (r < 12) begin
      foreach (words[i]) send_word(16'($urandom), $urandom_range(3) == 0, 1'b0, '0);
    end else begin
      head_bs = restart_next || ($urandom_range(4) == 0);
      restart_next = 1'b0;
      foreach (words[i]) send_word(words[i], (i == 0) ? head_bs : 1'b0, 1'b0, '0);
    end
  endtask

  function automatic frame_t mk_frame(logic av, logic [15:0] ax, logic [15:0] ay,
                                      logic [15:0] az, logic gv, logic [15:0] gx,
                                      logic [15:0] gy, logic [15:0] gz, logic tv,
                                      logic [15:0] t, logic [63:0] ts);
    return {av, ax, ay, az, gv, gx, gy, gz, tv, t, ts};
  endfunction

  function automatic row_t word_row(logic [15:0] w, logic bs);
    row_t r;
    r = '{kind: ROW_WORD, word: w, bs: bs, typed: 1'b0, frame: '0, en: '0,
          acc_dummy: '0, gyr_dummy: '0, temp_dummy: '0};
    return r;
  endfunction

  function automatic row_t typed_row(logic [15:0] w, logic bs, frame_t f);
    row_t r;
    r = word_row(w, bs);
    r.typed = 1'b1;
    r.frame = f;
    return r;
  endfunction

  function automatic row_t cfg_row(enables_t e, logic [15:0] ad, logic [15:0] gd,
                                   logic [15:0] td);
    row_t r;
    r = word_row('0, 1'b0);
    r.kind       = ROW_CFG;
    r.en         = e;
    r.acc_dummy  = ad;
    r.gyr_dummy  = gd;
    r.temp_dummy = td;
    return r;
  endfunction

  // stimulus
  initial begin
    enables_t pick;
    int       start;
    bit       paused;
    rst                 = 1'b1;
    word_ch.valid       = 1'b0;
    word_ch.fifo_word   = '0;
    word_ch.batch_start = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = '0;
    cfg_ch.data         = '0;
    table_frame_on      = 1'b0;
    table_frame         = '0;
    src_idle_pct        = 0;
    sink_stall_pct      = 0;
    words_sent          = 0;
    settings_used       = 0;
    time_clock          = '0;
    restart_next        = 1'b0;
    model_reset();

    // time-only layout after reset, rollovers on backward steps
    dir_rows.push_back(typed_row(16'h0005, 1'b1, mk_frame(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 64'h5)));
    dir_rows.push_back(typed_row(16'h0003, 1'b0,
                                 mk_frame(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 64'h1_0003)));
    dir_rows.push_back(typed_row(16'h0000, 1'b0,
                                 mk_frame(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 64'h2_0000)));
    // full layout: dummy accel, extreme gyro, dummy temperature
    dir_rows.push_back(cfg_row(enables_t'(4'b1111), RST_ACC_DUMMY, RST_GYR_DUMMY,
                               RST_TEMP_DUMMY));
    dir_rows.push_back(word_row(16'h7F01, 1'b0));
    dir_rows.push_back(word_row(16'h1234, 1'b0));
    dir_rows.push_back(word_row(16'h5678, 1'b0));
    dir_rows.push_back(word_row(16'h8000, 1'b0));
    dir_rows.push_back(word_row(16'h7FFF, 1'b0));
    dir_rows.push_back(word_row(16'h0000, 1'b0));
    dir_rows.push_back(word_row(16'h8000, 1'b0));
    dir_rows.push_back(typed_row(16'hFFFF, 1'b0, mk_frame(0, 0, 0, 0, 1, 16'h8000, 16'h7FFF,
                                                          16'h0000, 0, 0, 64'h2_FFFF)));
    // valid accel, dummy gyro, valid temperature, time wraps
    dir_rows.push_back(word_row(16'hFFFF, 1'b0));
    dir_rows.push_back(word_row(16'h0001, 1'b0));
    dir_rows.push_back(word_row(16'h8000, 1'b0));
    dir_rows.push_back(word_row(16'h7F02, 1'b0));
    dir_rows.push_back(word_row(16'hAAAA, 1'b0));
    dir_rows.push_back(word_row(16'h5555, 1'b0));
    dir_rows.push_back(word_row(16'h7FFF, 1'b0));
    dir_rows.push_back(word_row(16'h0001, 1'b0));
    // partial frame, then a shorter layout leaves the position past the end
    dir_rows.push_back(word_row(16'h0F0F, 1'b0));
    dir_rows.push_back(word_row(16'hF0F0, 1'b0));
    dir_rows.push_back(cfg_row(enables_t'(4'b0011), RST_ACC_DUMMY, RST_GYR_DUMMY, 16'h0000));
    dir_rows.push_back(word_row(16'h8000, 1'b0));
    dir_rows.push_back(word_row(16'h0002, 1'b0));
    // batch start drops the partial frame
    dir_rows.push_back(word_row(16'h0000, 1'b0));
    dir_rows.push_back(word_row(16'h1234, 1'b1));
    dir_rows.push_back(word_row(16'h0003, 1'b0));
    // nothing enabled: word ignored
    dir_rows.push_back(cfg_row(enables_t'(4'b0000), 16'hFFFF, 16'hFFFF, 16'hFFFF));
    dir_rows.push_back(word_row(16'h4321, 1'b1));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_CFG: begin
          drain();
          configure(dir_rows[i].en, dir_rows[i].acc_dummy, dir_rows[i].gyr_dummy,
                    dir_rows[i].temp_dummy);
        end
        default: send_word(dir_rows[i].word, dir_rows[i].bs, dir_rows[i].typed,
                           dir_rows[i].frame);
      endcase
    end

    // random frames over the idle mixes, three register settings each
    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct   = SRC_IDLE[ph];
      sink_stall_pct = SINK_STALL[ph];
      for (int s = 0; s < 3; s++) begin
        drain();
        if (s == 0) begin
          configure(enables_t'(4'b1111), 16'h0000, 16'h0000, 16'h0000);
        end else if (s == 1) begin
          pick = enables_t'($urandom_range(1, 15));
          configure(pick, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        end else begin
          pick = enables_t'($urandom_range(0, 15));
          configure(pick, 16'($urandom), 16'($urandom), 16'($urandom));
        end
        restart_next = 1'b1;
        if (frame_len() == 0) begin
          repeat (8) send_word(16'($urandom), $urandom_range(1), 1'b0, '0);
        end else begin
          start  = words_sent;
          paused = 1'b0;
          while (words_sent - start < SETTING_WORDS) begin
            send_frame();
            if (!paused && words_sent - start >= SETTING_WORDS / 2) begin
              wait_for_frames();
              paused = 1'b1;
            end
          end
        end
      end
    end

    drain();
    $display("covered %0d fifo words under %0d register settings, %0d frames compared",
             words_sent, settings_used, frames_checked);
    $display("idle mixes: none, sender 52%%, receiver 52%%, both 21%%; %0d mismatches",
             mismatches);
    if (mismatches == 0 && pending_frames.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
